@@ src/spq_pkg.sv @@
package spq_pkg;

  // Operation codes carried in s_axis_tuser
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    start;        // capture the accepted item, reset the sweep
    logic    op_deq;       // current operation is a dequeue
    logic    run;          // sweep the held entries
    logic    tail;         // write the carried entry behind the last one
    logic    load_result;  // load the output register
    status_t status;       // status of the current operation
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;  // no entries held
    logic full;   // every slot held
    logic last;   // the entry read back is the last held one
  } sts_t;

endpackage

@@ src/spq_ram.sv @@
module spq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/spq_ctrl.sv @@
module spq_ctrl
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic in_op_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RUN    = 2'd1;
  localparam logic [1:0] S_TAIL   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       op_q, op_d;
  status_t    status_q, status_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       load;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  // Sequence one operation at a time
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = in_op_i;
          status_d = STAT_OK;
          if (in_op_i == OP_DEQ) begin
            if (sts_i.empty) begin
              status_d = STAT_EMPTY;
              state_d  = S_FINISH;
            end else begin
              state_d = S_RUN;
            end
          end else begin
            if (sts_i.full) begin
              status_d = STAT_FULL;
              state_d  = S_FINISH;
            end else if (sts_i.empty) begin
              state_d = S_TAIL;
            end else begin
              state_d = S_RUN;
            end
          end
        end
      end
      S_RUN: begin
        if (sts_i.last) begin
          state_d = (op_q == OP_DEQ) ? S_FINISH : S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result until the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ENQ;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.start       = accept;
    cmd_o.op_deq      = (op_q == OP_DEQ);
    cmd_o.run         = (state_q == S_RUN);
    cmd_o.tail        = (state_q == S_TAIL);
    cmd_o.load_result = load;
    cmd_o.status      = status_q;
  end

endmodule

@@ src/spq_dp.sv @@
module spq_dp
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic [31:0] item_data_i,
  input  logic [15:0] item_priority_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic [31:0] res_data_o,
  output status_t     res_status_o,
  output logic [4:0]  res_count_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = DATA_BITS + 16;

  logic                 mode_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        issue_q;
  logic                 rvalid_q;
  logic                 ins_q;
  logic [AW-1:0]        proc_q;
  logic [EW-1:0]        carry_q;
  logic [DATA_BITS-1:0] out_q;
  logic [31:0]          res_data_q;
  status_t              res_status_q;
  logic [4:0]           res_count_q;

  logic [DATA_BITS+31:0] in_ext;
  logic [DATA_BITS+31:0] out_ext;
  logic [CW+4:0]         count_ext;
  logic [EW-1:0]         new_entry;
  logic [EW-1:0]         rdata;
  logic signed [15:0]    rprio;
  logic signed [15:0]    cprio;
  logic                  ahead;
  logic                  issue_go;
  logic                  last;
  logic                  displace;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [EW-1:0]         wdata;

  assign in_ext    = {{DATA_BITS{1'b0}}, item_data_i};
  assign new_entry = {item_priority_i, in_ext[DATA_BITS-1:0]};
  assign out_ext   = {32'd0, out_q};
  assign count_ext = {5'd0, count_q};

  // Sweep the held entries from the head, one read per cycle
  assign issue_go = cmd_i.run && (issue_q < count_q);
  assign last     = rvalid_q && (CW'(proc_q) == count_q - CW'(1));

  // Compare the entry read back against the entry still looking for its place
  assign rprio    = $signed(rdata[EW-1:DATA_BITS]);
  assign cprio    = $signed(carry_q[EW-1:DATA_BITS]);
  assign ahead    = mode_q ? (rprio > cprio) : (rprio < cprio);
  assign displace = rvalid_q && !cmd_i.op_deq && (ins_q || !ahead);

  // Drive the memory write port
  always_comb begin
    we    = 1'b0;
    waddr = proc_q;
    wdata = carry_q;
    if (cmd_i.tail) begin
      we    = 1'b1;
      waddr = count_q[AW-1:0];
    end else if (rvalid_q && cmd_i.op_deq) begin
      if (proc_q != '0) begin
        we    = 1'b1;
        waddr = proc_q - AW'(1);
        wdata = rdata;
      end
    end else if (displace) begin
      we = 1'b1;
    end
  end

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue_go),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      count_q  <= '0;
      issue_q  <= '0;
      rvalid_q <= 1'b0;
      ins_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        issue_q  <= '0;
        rvalid_q <= 1'b0;
        ins_q    <= 1'b0;
      end else begin
        rvalid_q <= issue_go;
        if (issue_go) begin
          issue_q <= issue_q + CW'(1);
        end
        if (displace) begin
          ins_q <= 1'b1;
        end
      end
      if (cmd_i.tail) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.op_deq && last) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (issue_go) begin
      proc_q <= issue_q[AW-1:0];
    end
    if (cmd_i.start) begin
      carry_q <= new_entry;
      out_q   <= '0;
    end else begin
      if (displace) begin
        carry_q <= rdata;
      end
      if (rvalid_q && cmd_i.op_deq && (proc_q == '0)) begin
        out_q <= rdata[DATA_BITS-1:0];
      end
    end
    if (cmd_i.load_result) begin
      res_data_q   <= out_ext[31:0];
      res_status_q <= cmd_i.status;
      res_count_q  <= count_ext[4:0];
    end
  end

  always_comb begin
    sts_o.empty = (count_q == '0);
    sts_o.full  = (count_q == CW'(QUEUE_DEPTH));
    sts_o.last  = last;
  end

  assign res_data_o   = res_data_q;
  assign res_status_o = res_status_q;
  assign res_count_o  = res_count_q;

endmodule

@@ src/sorted_priority_queue.sv @@
// Priority queue of up to QUEUE_DEPTH entries held in one memory in sorted
// order, head at slot 0. An operation is a transfer on the slave stream with
// tuser selecting enqueue (0) or dequeue (1); each one returns exactly one
// result on the master stream carrying the dequeued payload (0 when none),
// a status (0 ok, 1 dequeue on empty, 2 enqueue on full) and the entry count
// afterwards. order_mode 0 lets the lowest priority leave first, 1 the
// highest; among equal priorities the newest entry leaves first. Held entries
// are not re-sorted when the mode changes. Operations run one at a time,
// each sweeping the held entries through the memory's read and write
// ports, one entry per cycle; an enqueue into an empty queue skips the
// sweep, and a dequeue on empty or an enqueue on full goes straight to
// its result. The next input transfer is taken the cycle after the result
// is loaded, even if that result still waits to be taken.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // order_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // item_data[31:0], item_priority[47:32]
  input  logic [0:0]  s_axis_tuser,   // op[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // out_data[31:0], status[33:32], entry_count[38:34]
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] res_data;
  status_t     res_status;
  logic [4:0]  res_count;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_BITS   (DATA_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .item_data_i     (s_axis_tdata[31:0]),
    .item_priority_i (s_axis_tdata[47:32]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .res_data_o      (res_data),
    .res_status_o    (res_status),
    .res_count_o     (res_count)
  );

  assign m_axis_tdata = {1'b0, res_count, res_status, res_data};

  // Never write behind the last slot
  a_tail_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tail |-> !sts.full)
    else $error("tail write with queue full");

  // A full status leaves the queue full
  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_result && cmd.status == STAT_FULL) |-> sts.full)
    else $error("full status reported on a queue that is not full");

  // An empty status leaves the queue empty
  a_empty_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_result && cmd.status == STAT_EMPTY) |-> sts.empty)
    else $error("empty status reported on a queue that holds entries");

  // No read data is in flight while a new item can be taken
  a_idle_no_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !sts.last && !cmd.run)
    else $error("sweep still active while accepting input");

endmodule
